/* rtl/cqe_pkg.sv */
// Shared constants and types of the circular queue engine.
// Command and status codes, default depth, register width and control state.
// No dependencies.
package cqe_pkg;

  localparam int DefaultDepth = 64;
  localparam int SizeW        = 7;
  localparam int DataW        = 32;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(64);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SHOW = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

endpackage

/* rtl/circular_queue_engine.sv */
// Circular FIFO engine top level: entry memory, head/count pointers, read walk.
// Depends on cqe_pkg.
//
// Each request is a command. Enqueue and the empty or full cases give one result straight into
// the output register. Dequeue goes through acceptance, one read of the entry memory, then the
// load of the output register. Display of N stored entries reads one entry per cycle from the
// memory read port and pauses while the output is stalled; no request is taken until the walk
// has drained. A pending configuration write holds requests off. Writing queue_size empties
// the queue. Entry memory is not cleared after reset; only written slots are ever read.
module circular_queue_engine
  import cqe_pkg::*;
#(
  parameter int DEPTH = DefaultDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              command,
  input  logic signed [DataW-1:0] element,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] value,
  output logic [1:0]              status,
  output logic                    last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SizeW-1:0]        cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [SizeW:0] DepthQ = (SizeW+1)'(DEPTH);

  state_t              state, state_next;
  logic [SizeW-1:0]    queue_size;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       ptr, ptr_next;
  logic [CW-1:0]       rem, rem_next;
  logic                pend, pend_next;
  logic                pend_last, pend_last_next;
  logic [DataW-1:0]    mem [DEPTH];
  logic [DataW-1:0]    rd_data;

  logic [CW-1:0]       ring_len;
  logic                out_free, accept, full, rd_en, wr_en, out_load, walk_start;
  logic [CW:0]         enq_sum, head_inc, ptr_inc;
  logic [AW-1:0]       wr_addr;
  logic [DataW-1:0]    load_value;
  status_t             load_status;
  logic                load_last;
  cmd_t                cmd;

  assign cmd = cmd_t'(command);

  always_comb begin
    if (queue_size == '0) begin
      ring_len = CW'(1);
    end else if ({1'b0, queue_size} > DepthQ) begin
      ring_len = CW'(DEPTH);
    end else begin
      ring_len = CW'(queue_size);
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free && !cfg_valid);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count >= ring_len);

  assign enq_sum  = (CW+1)'(head) + (CW+1)'(count);
  assign head_inc = (CW+1)'(head) + (CW+1)'(1);
  assign ptr_inc  = (CW+1)'(ptr) + (CW+1)'(1);
  assign wr_addr  = (enq_sum >= (CW+1)'(ring_len)) ?
                    AW'(enq_sum - (CW+1)'(ring_len)) : AW'(enq_sum);

  assign wr_en      = accept && (cmd == CMD_ENQ) && !full;
  assign walk_start = accept && ((cmd == CMD_DEQ) || (cmd == CMD_SHOW)) && (count != '0);
  assign rd_en      = (state == S_WALK) && (rem != '0) && (!pend || out_free);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    ptr_next       = ptr;
    rem_next       = rem;
    pend_next      = pend;
    pend_last_next = pend_last;
    out_load       = 1'b0;
    load_value     = rd_data;
    load_status    = ST_OK;
    load_last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          head_next  = '0;
          count_next = '0;
        end else if (accept) begin
          case (cmd)
            CMD_ENQ: begin
              out_load    = 1'b1;
              load_value  = '0;
              load_status = full ? ST_OVER : ST_OK;
              if (!full) begin
                count_next = count + CW'(1);
              end
            end
            CMD_DEQ: begin
              if (count == '0) begin
                out_load    = 1'b1;
                load_value  = '0;
                load_status = ST_UNDER;
              end else begin
                count_next = count - CW'(1);
                if (count == CW'(1) || head_inc >= (CW+1)'(ring_len)) begin
                  head_next = '0;
                end else begin
                  head_next = AW'(head_inc);
                end
              end
            end
            CMD_SHOW: begin
              if (count == '0) begin
                out_load    = 1'b1;
                load_value  = '0;
                load_status = ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
          if (walk_start) begin
            state_next = S_WALK;
            ptr_next   = head;
            rem_next   = (cmd == CMD_DEQ) ? CW'(1) : count;
          end
        end
      end
      S_WALK: begin
        if (pend && out_free) begin
          out_load  = 1'b1;
          load_last = pend_last;
          pend_next = 1'b0;
        end
        if (rd_en) begin
          pend_next      = 1'b1;
          pend_last_next = (rem == CW'(1));
          rem_next       = rem - CW'(1);
          ptr_next       = (ptr_inc >= (CW+1)'(ring_len)) ? '0 : AW'(ptr_inc);
        end
        if (rem_next == '0 && !pend_next) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= element;
    end
    if (rd_en) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      queue_size <= SizeReset;
      head       <= '0;
      count      <= '0;
      ptr        <= '0;
      rem        <= '0;
      pend       <= 1'b0;
      pend_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      ptr       <= ptr_next;
      rem       <= rem_next;
      pend      <= pend_next;
      pend_last <= pend_last_next;
      if (cfg_valid && cfg_ready) begin
        queue_size <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value  <= load_value;
      status <= load_status;
      last   <= load_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ring_len)
    else $error("occupancy beyond ring length");

  a_walk_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> in_stall)
    else $error("request taken during read walk");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (rem == '0 && !pend))
    else $error("idle with reads outstanding");

  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    (pend && !out_free) |=> (pend && $stable(rd_data)))
    else $error("read data lost while output blocked");

  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("memory read and write in one cycle");
`endif

endmodule

/* tb/tb_circular_queue_engine.sv */
// Self-checking testbench for circular_queue_engine: directed table, then randomised phases.
// Depends on cqe_pkg and the circular_queue_engine RTL; predicts every result internally.
`timescale 1ns / 100ps
module tb_circular_queue_engine;
  import cqe_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int NumPhases     = 9;
  localparam int NumDirRows    = 29;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cmd_t                    cmd;
    logic signed [DataW-1:0] elem;
    logic                    typed;
    logic signed [DataW-1:0] exp_value;
    status_t                 exp_status;
  } dir_row_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    status_t                 status;
    logic                    last;
  } queue_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              command = CMD_NONE;
  logic signed [DataW-1:0] element = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] value;
  logic [1:0]              status;
  logic                    last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [SizeW-1:0]        cfg_data = '0;

  // fixed expectation carried alongside the request being offered
  logic                    row_typed = 1'b0;
  logic signed [DataW-1:0] row_value = '0;
  status_t                 row_status = ST_OK;

  logic                    quiet = 1'b0;
  logic                    hold_req = 1'b0;
  int                      errors = 0;
  int                      idle_cycles = 0;

  queue_result_t           expected_results[$];

  logic signed [DataW-1:0] ring [DefaultDepth];
  logic [5:0]              ring_head = '0;
  logic [SizeW-1:0]        ring_count = '0;
  logic [SizeW-1:0]        ring_size = SizeReset;

  dir_row_t                dir_rows [NumDirRows];
  logic [SizeW-1:0]        phase_sizes [NumPhases];

  circular_queue_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .element   (element),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int ring_len();
    int n;
    n = ring_size;
    if (n == 0) return 1;
    if (n > DefaultDepth) return DefaultDepth;
    return n;
  endfunction

  function automatic int ring_slot(int offset);
    int n;
    int s;
    n = ring_len();
    s = (ring_head % n) + (offset % n);
    if (s >= n) s -= n;
    return s;
  endfunction

  function automatic void predict_queue_results(cmd_t c, logic signed [DataW-1:0] e,
                                                logic keep);
    queue_result_t r;
    int            n;
    n = ring_len();
    case (c)
      CMD_ENQ: begin
        if (ring_count >= n) begin
          r = '{value: '0, status: ST_OVER, last: 1'b1};
        end else begin
          ring[ring_slot(ring_count)] = e;
          ring_count++;
          r = '{value: '0, status: ST_OK, last: 1'b1};
        end
        if (keep) expected_results.push_back(r);
      end
      CMD_DEQ: begin
        if (ring_count == 0) begin
          r = '{value: '0, status: ST_UNDER, last: 1'b1};
        end else begin
          r = '{value: ring[ring_slot(0)], status: ST_OK, last: 1'b1};
          ring_count--;
          ring_head = (ring_count == 0) ? '0 : 6'(ring_slot(1));
        end
        if (keep) expected_results.push_back(r);
      end
      CMD_SHOW: begin
        if (ring_count == 0) begin
          if (keep) expected_results.push_back('{value: '0, status: ST_EMPTY, last: 1'b1});
        end else if (keep) begin
          for (int k = 0; k < ring_count; k++)
            expected_results.push_back('{value: ring[ring_slot(k)], status: ST_OK,
                                         last: (k + 1 == ring_count)});
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    queue_result_t want;
    logic          moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %h status %0d last %0b",
                   $time, value, status, last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, want.value, value);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        predict_queue_results(cmd_t'(command), element, !row_typed);
        if (row_typed)
          expected_results.push_back('{value: row_value, status: row_status, last: 1'b1});
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        ring_size  = cfg_data;
        ring_head  = '0;
        ring_count = '0;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // output side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input cmd_t c, input logic signed [DataW-1:0] e,
                              input logic typed, input logic signed [DataW-1:0] tv,
                              input status_t ts);
    in_valid   <= 1'b1;
    command    <= c;
    element    <= e;
    row_typed  <= typed;
    row_value  <= tv;
    row_status <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // wait until every expected result is out and the engine has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_queue_size(input logic [SizeW-1:0] size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [DataW-1:0] random_element();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    cmd_t c;
    int   r;
    int   n_items;
    int   enq_pct;
    int   deq_pct;

    foreach (ring[i]) ring[i] = '0;

    dir_rows = '{
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sd0,           ST_UNDER},
      '{ROW_CMD, CMD_SHOW, 32'sd0,           1'b1, 32'sd0,           ST_EMPTY},
      '{ROW_CMD, CMD_NONE, 32'sh1234_5678,   1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sh7FFF_FFFF,   1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sh8000_0000,   1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'shFFFF_FFFF,   1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_SHOW, 32'sd0,           1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sh7FFF_FFFF,   ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sh8000_0000,   ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'shFFFF_FFFF,   ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sd0,           ST_UNDER},
      '{ROW_CFG, CMD_NONE, 32'sd1,           1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd5,           1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd6,           1'b1, 32'sd0,           ST_OVER},
      '{ROW_CMD, CMD_SHOW, 32'sd0,           1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sd5,           ST_OK},
      '{ROW_CFG, CMD_NONE, 32'sd0,           1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd9,           1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd10,          1'b1, 32'sd0,           ST_OVER},
      '{ROW_CFG, CMD_NONE, 32'sd3,           1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sd0,           ST_UNDER},
      '{ROW_CMD, CMD_ENQ,  32'sd1,           1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd2,           1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b1, 32'sd1,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd3,           1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd4,           1'b1, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_SHOW, 32'sd0,           1'b0, 32'sd0,           ST_OK},
      '{ROW_CMD, CMD_ENQ,  32'sd5,           1'b1, 32'sd0,           ST_OVER},
      '{ROW_CMD, CMD_DEQ,  32'sd0,           1'b0, 32'sd0,           ST_OK}
    };

    phase_sizes = '{7'd64, 7'd5, 7'd1, 7'd0, 7'd127, 7'd2,
                    SizeW'($urandom_range(1, 16)), 7'd3, 7'd64};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_queue_size(SizeW'(dir_rows[i].elem));
      end else begin
        send_request(dir_rows[i].cmd, dir_rows[i].elem, dir_rows[i].typed,
                     dir_rows[i].exp_value, dir_rows[i].exp_status);
        sender_gap();
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      write_queue_size(phase_sizes[ph]);
      quiet   = (ph == NumPhases - 1);
      n_items = (ph == 0) ? 80 : 18;
      enq_pct = (ph % 3 == 1) ? 30 : (ph % 3 == 2) ? 45 : 60;
      deq_pct = (ph % 3 == 1) ? 55 : 35;
      // first phase starts under a long output hold, then fills the full ring and walks it
      if (ph == 0) hold_req = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 4 && i == n_items / 2) settle();
        r = $urandom_range(0, 99);
        if (ph == 0 && i < 66)       c = CMD_ENQ;
        else if (ph == 0 && i == 66) c = CMD_SHOW;
        else if (r < enq_pct)        c = CMD_ENQ;
        else if (r < enq_pct + deq_pct) c = CMD_DEQ;
        else if (r < 96)             c = CMD_SHOW;
        else                         c = CMD_NONE;
        send_request(c, random_element(), 1'b0, '0, ST_OK);
        sender_gap();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
